// File: design/e2q_pkg.sv
// Shared types, constants and elaboration-time helpers for the Euler to quaternion block.
package e2q_pkg;

  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int OUT_FRAC_BITS     = 14;
  localparam int SINCOS_ITERATIONS = 16;
  localparam int MAX_STEPS         = 32;

  // Rotation steps actually performed.
  localparam int STEPS = (SINCOS_ITERATIONS < MAX_STEPS) ? SINCOS_ITERATIONS : MAX_STEPS;

  localparam int ANGLE_W     = 16;
  localparam int OUT_W       = 16;
  localparam int CORDIC_FRAC = 30;
  localparam int CORDIC_W    = 32;
  localparam int PROD_W      = 2 * CORDIC_W;
  localparam int SUM_W       = PROD_W + 1;

  localparam int LANE_STAGES  = STEPS + 1;
  localparam int MERGE_STAGES = 5;
  localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [OUT_W-1:0]    part_t;
  typedef logic signed [2*OUT_W+1:0]  norm_t;

  typedef struct packed {
    part_t w;
    part_t x;
    part_t y;
    part_t z;
  } quat_t;

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  // Pi rounded to nearest in the angle format.
  localparam angle_t ANGLE_LIMIT =
    angle_t'((PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS));

  // Shift that turns an angle into its half in the rotation format.
  localparam int HALF_SHIFT = CORDIC_FRAC - 1 - ANGLE_FRAC_BITS;

  localparam int FIN_SHIFT = 2 * CORDIC_FRAC - OUT_FRAC_BITS;

  localparam longint OUT_ONE = 64'sd1 <<< OUT_FRAC_BITS;
  localparam longint OUT_MAX = (OUT_ONE > 64'sd32767) ? 64'sd32767 : OUT_ONE;
  localparam longint OUT_MIN = (-OUT_ONE < -64'sd32768) ? -64'sd32768 : -OUT_ONE;

  localparam norm_t NORM_ONE = norm_t'(OUT_ONE * OUT_ONE);
  localparam norm_t NORM_TOL = norm_t'((OUT_ONE * OUT_ONE) >>> 8);

  // Arctangent of 2^-i in Q.30.
  function automatic cordic_t atan_q30(input int i);
    cordic_t r;
    case (i)
      0:       r = 32'sh3243F6A9;
      1:       r = 32'sh1DAC6705;
      2:       r = 32'sh0FADBAFD;
      3:       r = 32'sh07F56EA7;
      4:       r = 32'sh03FEAB77;
      5:       r = 32'sh01FFD55C;
      6:       r = 32'sh00FFFAAB;
      7:       r = 32'sh007FFF55;
      8:       r = 32'sh003FFFEB;
      9:       r = 32'sh001FFFFD;
      default: begin
        if (i < CORDIC_FRAC + 1) begin
          r = cordic_t'(64'sd1 <<< (CORDIC_FRAC - i));
        end else begin
          r = cordic_t'(1);
        end
      end
    endcase
    return r;
  endfunction

  // Start value of the rotation: 2^30 scaled down by each step's stretch, with the
  // same truncations as the arithmetic definition. The quotient is found by a bit search.
  function automatic cordic_t gain_q30();
    logic [63:0] g;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] cand;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] rbit;
    int i;
    int k;
    int b;
    g = 64'd1 << CORDIC_FRAC;
    for (i = 0; i < STEPS; i++) begin
      v = 64'd1 << 60;
      if (2 * i <= 60) begin
        v = v + (64'd1 << (60 - 2 * i));
      end
      res  = '0;
      rbit = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
        if (v >= res + rbit) begin
          v   = v - (res + rbit);
          res = (res >> 1) + rbit;
        end else begin
          res = res >> 1;
        end
        rbit = rbit >> 2;
      end
      num = g << CORDIC_FRAC;
      q   = '0;
      for (b = 31; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        if (cand * res <= num) begin
          q = cand;
        end
      end
      g = q;
    end
    return cordic_t'(g);
  endfunction

  // Round a Q.60 product to Q.30.
  function automatic cordic_t round_pair(input prod_t p);
    prod_t t;
    t = p + (prod_t'(1) <<< (CORDIC_FRAC - 1));
    return t[CORDIC_FRAC+CORDIC_W-1:CORDIC_FRAC];
  endfunction

  // Round a Q.60 sum to the output format and saturate.
  function automatic part_t finish(input sum_t s);
    sum_t t;
    t = s + (sum_t'(1) <<< (FIN_SHIFT - 1));
    t = t >>> FIN_SHIFT;
    if (t > sum_t'(OUT_MAX)) begin
      t = sum_t'(OUT_MAX);
    end else if (t < sum_t'(OUT_MIN)) begin
      t = sum_t'(OUT_MIN);
    end
    return t[OUT_W-1:0];
  endfunction

endpackage

// File: design/e2q_sincos_lane.sv
// One angle lane: clamp, halve, and a pipelined rotation-mode CORDIC giving cosine and sine.
module e2q_sincos_lane (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::angle_t   angle,
  output e2q_pkg::cordic_t  cos_val,
  output e2q_pkg::cordic_t  sin_val
);

  localparam e2q_pkg::cordic_t GAIN = e2q_pkg::gain_q30();

  e2q_pkg::angle_t  angle_clamped;
  e2q_pkg::cordic_t x [0:e2q_pkg::STEPS];
  e2q_pkg::cordic_t y [0:e2q_pkg::STEPS];
  e2q_pkg::cordic_t z [0:e2q_pkg::STEPS-1];

  always_comb begin
    if (angle > e2q_pkg::ANGLE_LIMIT) begin
      angle_clamped = e2q_pkg::ANGLE_LIMIT;
    end else if (angle < -e2q_pkg::ANGLE_LIMIT) begin
      angle_clamped = -e2q_pkg::ANGLE_LIMIT;
    end else begin
      angle_clamped = angle;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GAIN;
      y[0] <= '0;
      z[0] <= e2q_pkg::cordic_t'(angle_clamped) <<< e2q_pkg::HALF_SHIFT;
    end
  end

  for (genvar i = 0; i < e2q_pkg::STEPS; i++) begin : g_step
    localparam e2q_pkg::cordic_t ATAN_I = e2q_pkg::atan_q30(i);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][e2q_pkg::CORDIC_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
        end
      end
    end

    // The residual angle is not needed after the last step.
    if (i < e2q_pkg::STEPS - 1) begin : g_resid
      always_ff @(posedge clk) begin
        if (en) begin
          if (!z[i][e2q_pkg::CORDIC_W-1]) begin
            z[i+1] <= z[i] - ATAN_I;
          end else begin
            z[i+1] <= z[i] + ATAN_I;
          end
        end
      end
    end
  end

  assign cos_val = x[e2q_pkg::STEPS];
  assign sin_val = y[e2q_pkg::STEPS];

endmodule

// File: design/e2q_merge.sv
// Combines the three lanes' half-angle sines and cosines into the four quaternion parts.
module e2q_merge (
  input  logic              clk,
  input  logic              en,
  input  e2q_pkg::cordic_t  cx,
  input  e2q_pkg::cordic_t  sx,
  input  e2q_pkg::cordic_t  cy,
  input  e2q_pkg::cordic_t  sy,
  input  e2q_pkg::cordic_t  cz,
  input  e2q_pkg::cordic_t  sz,
  output e2q_pkg::quat_t    quat
);

  // First stage: pair products.
  e2q_pkg::prod_t   p_cxcy, p_sxsy, p_sxcy, p_cxsy;
  e2q_pkg::cordic_t cz1, sz1;
  // Second stage: pair products rounded to Q.30.
  e2q_pkg::cordic_t r_cxcy, r_sxsy, r_sxcy, r_cxsy;
  e2q_pkg::cordic_t cz2, sz2;
  // Third stage: triple products.
  e2q_pkg::prod_t   t_w0, t_w1, t_x0, t_x1, t_y0, t_y1, t_z0, t_z1;
  // Fourth stage: sums.
  e2q_pkg::sum_t    s_w, s_x, s_y, s_z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cxcy <= cx * cy;
      p_sxsy <= sx * sy;
      p_sxcy <= sx * cy;
      p_cxsy <= cx * sy;
      cz1    <= cz;
      sz1    <= sz;

      r_cxcy <= e2q_pkg::round_pair(p_cxcy);
      r_sxsy <= e2q_pkg::round_pair(p_sxsy);
      r_sxcy <= e2q_pkg::round_pair(p_sxcy);
      r_cxsy <= e2q_pkg::round_pair(p_cxsy);
      cz2    <= cz1;
      sz2    <= sz1;

      t_w0 <= r_cxcy * cz2;
      t_w1 <= r_sxsy * sz2;
      t_x0 <= r_sxcy * cz2;
      t_x1 <= r_cxsy * sz2;
      t_y0 <= r_cxsy * cz2;
      t_y1 <= r_sxcy * sz2;
      t_z0 <= r_cxcy * sz2;
      t_z1 <= r_sxsy * cz2;

      s_w <= e2q_pkg::sum_t'(t_w0) + e2q_pkg::sum_t'(t_w1);
      s_x <= e2q_pkg::sum_t'(t_x0) - e2q_pkg::sum_t'(t_x1);
      s_y <= e2q_pkg::sum_t'(t_y0) + e2q_pkg::sum_t'(t_y1);
      s_z <= e2q_pkg::sum_t'(t_z0) - e2q_pkg::sum_t'(t_z1);

      quat.w <= e2q_pkg::finish(s_w);
      quat.x <= e2q_pkg::finish(s_x);
      quat.y <= e2q_pkg::finish(s_y);
      quat.z <= e2q_pkg::finish(s_z);
    end
  end

endmodule

// File: design/euler_to_quaternion_top.sv
// Top level of the Euler angle to quaternion converter: lanes, merge and output buffer.
//
// Converts roll, pitch and yaw (Q2.13 radians, clamped to plus or minus pi) into the
// unit quaternion w, x, y, z in Q1.14. One item is taken per clock cycle when the
// output keeps draining. The item enters the first lane register at the edge that
// takes it; from there it passes the 16-step CORDIC pipeline in each of the three
// angle lanes, five multiply, rounding and summing stages in the merge unit and one
// output register. A two-entry output buffer lets the pipeline keep moving until the
// skid entry fills after the consumer stalls; in_stall is a registered signal.
module euler_to_quaternion_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  e2q_pkg::angle_t roll_angle,
  input  e2q_pkg::angle_t pitch_angle,
  input  e2q_pkg::angle_t yaw_angle,
  output logic            out_valid,
  input  logic            out_stall,
  output e2q_pkg::part_t  w_part,
  output e2q_pkg::part_t  x_part,
  output e2q_pkg::part_t  y_part,
  output e2q_pkg::part_t  z_part
);

  logic                             adv;
  logic [e2q_pkg::PIPE_STAGES-1:0]  pipe_valid;
  logic                             skid_valid;
  e2q_pkg::cordic_t                 cx, sx, cy, sy, cz, sz;
  e2q_pkg::quat_t                   merged;
  e2q_pkg::quat_t                   out_q;
  e2q_pkg::quat_t                   skid_q;
  logic                             pipe_done;

  // The whole pipeline moves together whenever the buffer has room.
  assign adv       = !skid_valid;
  assign in_stall  = skid_valid;
  assign pipe_done = adv && pipe_valid[e2q_pkg::PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (adv) begin
      pipe_valid <= {pipe_valid[e2q_pkg::PIPE_STAGES-2:0], in_valid};
    end
  end

  e2q_sincos_lane u_lane_roll (
    .clk     (clk),
    .en      (adv),
    .angle   (roll_angle),
    .cos_val (cx),
    .sin_val (sx)
  );

  e2q_sincos_lane u_lane_pitch (
    .clk     (clk),
    .en      (adv),
    .angle   (pitch_angle),
    .cos_val (cy),
    .sin_val (sy)
  );

  e2q_sincos_lane u_lane_yaw (
    .clk     (clk),
    .en      (adv),
    .angle   (yaw_angle),
    .cos_val (cz),
    .sin_val (sz)
  );

  e2q_merge u_merge (
    .clk  (clk),
    .en   (adv),
    .cx   (cx),
    .sx   (sx),
    .cy   (cy),
    .sy   (sy),
    .cz   (cz),
    .sz   (sz),
    .quat (merged)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (pipe_done) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= pipe_done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (pipe_done) begin
        skid_q <= merged;
      end
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (pipe_done) begin
      out_q <= merged;
    end
  end

  assign w_part = out_q.w;
  assign x_part = out_q.x;
  assign y_part = out_q.y;
  assign z_part = out_q.z;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> pipe_valid[0])
    else $error("accepted item did not enter the first stage");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the output register is empty");

  a_part_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (w_part <= e2q_pkg::part_t'(e2q_pkg::OUT_MAX))
               && (w_part >= e2q_pkg::part_t'(e2q_pkg::OUT_MIN))
               && (z_part <= e2q_pkg::part_t'(e2q_pkg::OUT_MAX))
               && (z_part >= e2q_pkg::part_t'(e2q_pkg::OUT_MIN)))
    else $error("quaternion part outside the saturation range");

  a_unit_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((e2q_pkg::norm_t'(w_part) * e2q_pkg::norm_t'(w_part)
        + e2q_pkg::norm_t'(x_part) * e2q_pkg::norm_t'(x_part)
        + e2q_pkg::norm_t'(y_part) * e2q_pkg::norm_t'(y_part)
        + e2q_pkg::norm_t'(z_part) * e2q_pkg::norm_t'(z_part))
       < e2q_pkg::NORM_ONE + e2q_pkg::NORM_TOL)
      && ((e2q_pkg::norm_t'(w_part) * e2q_pkg::norm_t'(w_part)
        + e2q_pkg::norm_t'(x_part) * e2q_pkg::norm_t'(x_part)
        + e2q_pkg::norm_t'(y_part) * e2q_pkg::norm_t'(y_part)
        + e2q_pkg::norm_t'(z_part) * e2q_pkg::norm_t'(z_part))
       > e2q_pkg::NORM_ONE - e2q_pkg::NORM_TOL))
    else $error("quaternion result is not close to unit length");
`endif

endmodule

// File: verif/euler_to_quaternion_top_test.sv
// Self-checking testbench for the Euler angle to quaternion converter.
module euler_to_quaternion_top_test;

  typedef struct packed {
    e2q_pkg::angle_t roll;
    e2q_pkg::angle_t pitch;
    e2q_pkg::angle_t yaw;
  } euler_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  e2q_pkg::angle_t roll_angle = '0;
  e2q_pkg::angle_t pitch_angle = '0;
  e2q_pkg::angle_t yaw_angle = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  e2q_pkg::part_t  w_part;
  e2q_pkg::part_t  x_part;
  e2q_pkg::part_t  y_part;
  e2q_pkg::part_t  z_part;

  euler_t          angle_pending[$];
  e2q_pkg::quat_t  quat_expected[$];

  longint atan_q30_tab[e2q_pkg::MAX_STEPS];
  longint rot_gain;
  int     total_items = 0;
  int     sent = 0;
  int     results_seen = 0;
  int     errors = 0;
  logic   in_fire = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_left = 0;

  euler_to_quaternion_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .w_part      (w_part),
    .x_part      (x_part),
    .y_part      (y_part),
    .z_part      (z_part)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint round_down_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Arctangent table from the truncated Taylor series, and the start value that
  // cancels the CORDIC stretch.
  function automatic void build_rotation_constants();
    longint      acc;
    longint      term;
    logic [63:0] g;
    logic [63:0] sq;
    int          e;
    atan_q30_tab[0] = round_down_shift(longint'(e2q_pkg::PI_Q61 >> 1), 32);
    for (int i = 1; i < e2q_pkg::MAX_STEPS; i++) begin
      acc = 0;
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = (64'sd1 <<< (62 - e)) / longint'(2 * k + 1);
          acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
      end
      atan_q30_tab[i] = round_down_shift(acc, 32);
    end
    g = 64'd1 << 30;
    for (int i = 0; i < e2q_pkg::STEPS; i++) begin
      sq = 64'd1 << 60;
      if (2 * i <= 60) sq = sq + (64'd1 << (60 - 2 * i));
      g = (g << 30) / isqrt64(sq);
    end
    rot_gain = longint'(g);
  endfunction

  function automatic void half_sin_cos(input e2q_pkg::angle_t ang, output longint c,
                                       output longint s);
    longint lim;
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    lim = longint'((e2q_pkg::PI_Q61 + (64'd1 << (60 - e2q_pkg::ANGLE_FRAC_BITS)))
                   >> (61 - e2q_pkg::ANGLE_FRAC_BITS));
    a = ang;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    z = a * (64'sd1 <<< (29 - e2q_pkg::ANGLE_FRAC_BITS));
    x = rot_gain;
    y = 0;
    for (int i = 0; i < e2q_pkg::STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q30_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q30_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint triple_q60(input longint a, input longint b, input longint c);
    return round_down_shift(a * b, 30) * c;
  endfunction

  function automatic e2q_pkg::part_t to_part(input longint sum);
    longint v;
    longint one;
    v   = round_down_shift(sum, 60 - e2q_pkg::OUT_FRAC_BITS);
    one = 64'sd1 <<< e2q_pkg::OUT_FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return e2q_pkg::part_t'(v);
  endfunction

  function automatic e2q_pkg::quat_t quat_from_euler(input euler_t e);
    longint         cx, sx, cy, sy, cz, sz;
    e2q_pkg::quat_t q;
    half_sin_cos(e.roll, cx, sx);
    half_sin_cos(e.pitch, cy, sy);
    half_sin_cos(e.yaw, cz, sz);
    q.w = to_part(triple_q60(cx, cy, cz) + triple_q60(sx, sy, sz));
    q.x = to_part(triple_q60(sx, cy, cz) - triple_q60(cx, sy, sz));
    q.y = to_part(triple_q60(cx, sy, cz) + triple_q60(sx, cy, sz));
    q.z = to_part(triple_q60(cx, cy, sz) - triple_q60(sx, sy, cz));
    return q;
  endfunction

  function automatic int sender_idle_pct(input int n);
    if (n < total_items / 3) return 6;
    if (n < 2 * total_items / 3) return 74;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    if (n < total_items / 3) return 74;
    if (n < 2 * total_items / 3) return 6;
    return 0;
  endfunction

  function automatic e2q_pkg::angle_t random_angle();
    int lim;
    int pick;
    lim  = int'(e2q_pkg::ANGLE_LIMIT);
    pick = $urandom_range(99);
    if (pick < 85) return e2q_pkg::angle_t'(int'($urandom_range(2 * lim)) - lim);
    if (pick < 95) return e2q_pkg::angle_t'($urandom);
    if (pick < 97) begin
      return e2q_pkg::angle_t'(lim - int'($urandom_range(3)) + int'($urandom_range(3)));
    end
    return e2q_pkg::angle_t'(-lim - int'($urandom_range(3)) + int'($urandom_range(3)));
  endfunction

  task automatic check_part(input string name, input e2q_pkg::part_t want,
                            input e2q_pkg::part_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin : send_angles
    euler_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (angle_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct(sent)) begin
        item = angle_pending.pop_front();
        roll_angle  <= item.roll;
        pitch_angle <= item.pitch;
        yaw_angle   <= item.yaw;
        in_valid    <= 1'b1;
        sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall; one long hold-off lets the pipeline back up into in_stall.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && results_seen >= (3 * total_items) / 4) begin
      hold_done <= 1'b1;
      hold_left <= 120;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct(sent));
    end
  end

  always @(posedge clk) begin : check_quat
    e2q_pkg::quat_t want;
    euler_t         got_in;
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (quat_expected.size() == 0) begin
          $error("unexpected result: w %0d x %0d y %0d z %0d", w_part, x_part, y_part, z_part);
          errors++;
        end else begin
          want = quat_expected.pop_front();
          check_part("w_part", want.w, w_part);
          check_part("x_part", want.x, x_part);
          check_part("y_part", want.y, y_part);
          check_part("z_part", want.z, z_part);
        end
      end
      if (in_valid && !in_stall) begin
        got_in.roll  = roll_angle;
        got_in.pitch = pitch_angle;
        got_in.yaw   = yaw_angle;
        quat_expected.push_back(quat_from_euler(got_in));
      end
    end
  end

  initial begin
    e2q_pkg::angle_t lim;
    e2q_pkg::angle_t half_pi;
    euler_t          e;
    build_rotation_constants();
    lim     = e2q_pkg::ANGLE_LIMIT;
    half_pi = e2q_pkg::angle_t'((int'(e2q_pkg::ANGLE_LIMIT) + 1) / 2);
    angle_pending.push_back('{16'sd0, 16'sd0, 16'sd0});
    angle_pending.push_back('{lim, 16'sd0, 16'sd0});
    angle_pending.push_back('{-lim, 16'sd0, 16'sd0});
    angle_pending.push_back('{16'sd0, lim, 16'sd0});
    angle_pending.push_back('{16'sd0, -lim, 16'sd0});
    angle_pending.push_back('{16'sd0, 16'sd0, lim});
    angle_pending.push_back('{16'sd0, 16'sd0, -lim});
    angle_pending.push_back('{lim, lim, lim});
    angle_pending.push_back('{-lim, -lim, -lim});
    // Out-of-range angles must clamp to the limit.
    angle_pending.push_back('{16'sd32767, -16'sd32768, 16'sd0});
    angle_pending.push_back('{-16'sd32768, 16'sd32767, 16'sd32767});
    angle_pending.push_back('{lim + 16'sd1, -lim - 16'sd1, lim + 16'sd1});
    angle_pending.push_back('{half_pi, half_pi, half_pi});
    angle_pending.push_back('{16'sd0, half_pi, 16'sd0});
    angle_pending.push_back('{16'sd0, -half_pi, 16'sd0});
    angle_pending.push_back('{lim, half_pi, -half_pi});
    angle_pending.push_back('{16'sd1, -16'sd1, 16'sd1});
    angle_pending.push_back('{-16'sd1, 16'sd1, -16'sd1});
    angle_pending.push_back('{lim, -lim, half_pi});
    for (int n = 0; n < 950; n++) begin
      e.roll  = random_angle();
      e.pitch = random_angle();
      e.yaw   = random_angle();
      angle_pending.push_back(e);
    end
    total_items = angle_pending.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (sent < total_items || in_valid) @(posedge clk);
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
design/e2q_pkg.sv
design/e2q_sincos_lane.sv
design/e2q_merge.sv
design/euler_to_quaternion_top.sv
verif/euler_to_quaternion_top_test.sv
